// ----- design/wahi_pkg.sv -----
// shared types, constants and functions of the weighted age histogram block
package wahi_pkg;

    localparam int MAX_BINS  = 16;
    localparam int NUM_EDGES = MAX_BINS - 1;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int EDGE_W    = 20;
    localparam int AGE_W     = 20;
    localparam int WEIGHT_W  = 16;
    localparam int TICK_W    = 16;
    localparam int ACC_W     = 32;
    localparam int TIME_W    = 24;
    localparam int NBINS_W   = 5;
    localparam int EIDX_W    = 4;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;
    localparam int PADDR_W   = 3;

    localparam logic [TIME_W-1:0]  INTERVAL_RESET = 24'd93440;
    localparam logic [NBINS_W-1:0] NBINS_RESET    = 5'd10;
    localparam int                 HALF_YEAR_Q4   = 2920;

    localparam logic [PADDR_W-1:0] ADDR_INTERVAL = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_NBINS    = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVENT = 2'd1,
        OP_TICK  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;
        logic edge_wr;
        logic find_bin;
        logic acc_wr;
        logic time_upd;
        logic emit_load;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic new_infection;
        logic time_nonzero;
        logic time_reached;
        logic emit_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [EDGE_W-1:0] edge_reset(input int i);
        edge_reset = EDGE_W'((i + 1) * HALF_YEAR_Q4);
    endfunction

endpackage

// ----- design/wahi_ctrl.sv -----
// controller state machine sequencing each request through the datapath
module wahi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  wahi_pkg::dp_status_t  sts,
    output wahi_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.opcode)
                    wahi_pkg::OP_LOAD:
                    begin
                        cmd.edge_wr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    wahi_pkg::OP_EVENT:
                    begin
                        if (sts.new_infection)
                        begin
                            cmd.find_bin = 1'b1;
                            state_next   = ST_ADD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    wahi_pkg::OP_TICK:
                    begin
                        cmd.time_upd = 1'b1;
                        state_next   = ST_CHECK;
                    end
                    wahi_pkg::OP_FLUSH:
                    begin
                        state_next = sts.time_nonzero ? ST_EMIT : ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                state_next = sts.time_reached ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.emit_load && sts.emit_last))
        else $error("counts cleared away from the last bin");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> sts.out_free)
        else $error("bin loaded while output register occupied");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next");

    a_add_after_find: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find_bin |=> cmd.acc_wr)
        else $error("bin search not followed by accumulate");

endmodule

// ----- design/wahi_dp.sv -----
// datapath: config registers, bin edges, accumulators, elapsed time, output register
module wahi_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wahi_pkg::ctrl_cmd_t                   cmd,
    output wahi_pkg::dp_status_t                  sts,
    input  logic [1:0]                            in_opcode,
    input  logic [wahi_pkg::IN_DATA_W-1:0]        in_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wahi_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [wahi_pkg::PADDR_W-1:0]          cfg_addr,
    input  logic [31:0]                           cfg_wdata,
    output logic [31:0]                           cfg_rdata
);

    localparam int BW = wahi_pkg::BIN_W;

    logic [wahi_pkg::TIME_W-1:0]   interval_reg;
    logic [wahi_pkg::NBINS_W-1:0]  nbins_reg;

    wahi_pkg::op_t                 op_reg;
    logic [wahi_pkg::EIDX_W-1:0]   eidx_reg;
    logic [wahi_pkg::EDGE_W-1:0]   edays_reg;
    logic                          newinf_reg;
    logic [wahi_pkg::AGE_W-1:0]    age_reg;
    logic [wahi_pkg::WEIGHT_W-1:0] weight_reg;
    logic [wahi_pkg::TICK_W-1:0]   tick_reg;

    logic [wahi_pkg::EDGE_W-1:0]   edge_reg [wahi_pkg::NUM_EDGES];
    logic [wahi_pkg::ACC_W-1:0]    acc_reg  [wahi_pkg::MAX_BINS];
    logic [wahi_pkg::TIME_W-1:0]   elapsed_reg;
    logic [BW-1:0]                 bin_reg;
    logic [BW-1:0]                 k_reg;

    logic                          ovalid_reg;
    logic [BW-1:0]                 oidx_reg;
    logic [wahi_pkg::ACC_W-1:0]    ocount_reg;
    logic                          olast_reg;

    logic [wahi_pkg::NBINS_W-1:0]  n_used;
    logic [BW-1:0]                 last_idx;
    logic [BW-1:0]                 found;
    logic [BW-1:0]                 rd_idx;
    logic [wahi_pkg::ACC_W-1:0]    rd_data;
    logic [wahi_pkg::ACC_W:0]      acc_sum;
    logic [wahi_pkg::ACC_W-1:0]    acc_next;
    logic [wahi_pkg::TIME_W:0]     time_sum;
    logic [wahi_pkg::TIME_W-1:0]   time_next;

    // bin count clamped to 1..MAX_BINS
    always_comb
    begin
        if (nbins_reg == '0)
        begin
            n_used = wahi_pkg::NBINS_W'(1);
        end
        else if (nbins_reg > wahi_pkg::NBINS_W'(wahi_pkg::MAX_BINS))
        begin
            n_used = wahi_pkg::NBINS_W'(wahi_pkg::MAX_BINS);
        end
        else
        begin
            n_used = nbins_reg;
        end
    end

    assign last_idx = BW'(n_used - wahi_pkg::NBINS_W'(1));

    // first used edge at or above the age, else catch-all bin
    always_comb
    begin
        found = last_idx;
        for (int i = wahi_pkg::NUM_EDGES - 1; i >= 0; i--)
        begin
            if ((wahi_pkg::NBINS_W'(i + 1) < n_used) && (edge_reg[i] >= age_reg))
            begin
                found = BW'(i);
            end
        end
    end

    assign rd_idx  = cmd.emit_load ? k_reg : bin_reg;
    assign rd_data = acc_reg[rd_idx];

    assign acc_sum  = {1'b0, rd_data} + (wahi_pkg::ACC_W + 1)'(weight_reg);
    assign acc_next = acc_sum[wahi_pkg::ACC_W] ? '1 : acc_sum[wahi_pkg::ACC_W-1:0];

    assign time_sum  = {1'b0, elapsed_reg} + (wahi_pkg::TIME_W + 1)'(tick_reg);
    assign time_next = time_sum[wahi_pkg::TIME_W] ? '1 : time_sum[wahi_pkg::TIME_W-1:0];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= wahi_pkg::INTERVAL_RESET;
            nbins_reg    <= wahi_pkg::NBINS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr[2] == wahi_pkg::ADDR_INTERVAL[2])
            begin
                interval_reg <= cfg_wdata[wahi_pkg::TIME_W-1:0];
            end
            else
            begin
                nbins_reg <= cfg_wdata[wahi_pkg::NBINS_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (cfg_addr[2] == wahi_pkg::ADDR_NBINS[2])
        begin
            cfg_rdata = 32'(nbins_reg);
        end
        else
        begin
            cfg_rdata = 32'(interval_reg);
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= wahi_pkg::op_t'(in_opcode);
            eidx_reg   <= in_data[3:0];
            edays_reg  <= in_data[23:4];
            newinf_reg <= in_data[24];
            age_reg    <= in_data[44:25];
            weight_reg <= in_data[60:45];
            tick_reg   <= in_data[76:61];
        end
        if (cmd.find_bin)
        begin
            bin_reg <= found;
        end
    end

    // bin edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wahi_pkg::NUM_EDGES; i++)
            begin
                edge_reg[i] <= wahi_pkg::edge_reset(i);
            end
        end
        else if (cmd.edge_wr)
        begin
            for (int i = 0; i < wahi_pkg::NUM_EDGES; i++)
            begin
                if (eidx_reg == wahi_pkg::EIDX_W'(i))
                begin
                    edge_reg[i] <= edays_reg;
                end
            end
        end
    end

    // accumulators, elapsed time and report counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wahi_pkg::MAX_BINS; i++)
            begin
                acc_reg[i] <= '0;
            end
            elapsed_reg <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < wahi_pkg::MAX_BINS; i++)
                begin
                    acc_reg[i] <= '0;
                end
                elapsed_reg <= '0;
                k_reg       <= '0;
            end
            else
            begin
                if (cmd.acc_wr)
                begin
                    acc_reg[bin_reg] <= acc_next;
                end
                if (cmd.time_upd)
                begin
                    elapsed_reg <= time_next;
                end
                if (cmd.emit_load)
                begin
                    k_reg <= k_reg + BW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            oidx_reg   <= k_reg;
            ocount_reg <= rd_data;
            olast_reg  <= (k_reg == last_idx);
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = wahi_pkg::OUT_DATA_W'({ocount_reg, 4'(oidx_reg)});
    assign m_tlast  = olast_reg;

    assign sts.opcode        = op_reg;
    assign sts.new_infection = newinf_reg;
    assign sts.time_nonzero  = (elapsed_reg != '0);
    assign sts.time_reached  = (elapsed_reg >= interval_reg);
    assign sts.emit_last     = (k_reg == last_idx);
    assign sts.out_free      = !ovalid_reg || m_tready;

endmodule

// ----- design/weighted_age_histogram_interval_top.sv -----
// top level of the weighted age histogram with programmable bin edges
//
// requests enter on the s_ stream: tuser is the opcode (load edge, event,
// tick, flush), tdata the operands. results leave on the m_ stream, one per
// reported bin, tlast on the final bin of a report run.
// the APB port sets the report interval (address 0) and the number of bins
// in use (address 4); write it only while the block is idle.
// one request is worked at a time. s_tready is high while the sequencer is
// idle; an edge load, an ignored event or a flush with no elapsed time
// returns to idle after the execute state, an event runs the bin search
// then the accumulate state, and a tick updates the elapsed time then
// checks it; a tick or flush that reports then loads one bin a cycle into
// the single output register while it is free.
// a reporting tick runs execute, check, then emit, which loads its first result.
// when the receiver stalls the report waits in the output register and the
// sequencer holds; a new request is taken as soon as the last bin is loaded.
// reset restores the default edges (half-year steps), clears the counts and
// the elapsed time and sets the interval to INTERVAL_RESET with ten bins.
module weighted_age_histogram_interval_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // edge_index, edge_days, new_infection, age_days, weight, tick_days
    input  logic [wahi_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_index, bin_count
    output logic [wahi_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wahi_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    wahi_pkg::ctrl_cmd_t  cmd;
    wahi_pkg::dp_status_t sts;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    wahi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wahi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_opcode (s_tuser),
        .in_data   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (paddr),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );

endmodule
